@@ hdl/ebic_pkg.sv @@
// Shared types, codes and constants of the encoder and button input conditioner.
package ebic_pkg;

  typedef enum logic [1:0] {
    FUNC_SAMPLE      = 2'd0,
    FUNC_TAKE_DELTA  = 2'd1,
    FUNC_TAKE_BUTTON = 2'd2,
    FUNC_TAKE_SWITCH = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_REST_TIMEOUT = 3'd1,
    REG_CLK_POS      = 3'd2,
    REG_DT_POS       = 3'd3,
    REG_SWITCH_POS   = 3'd4
  } reg_idx_t;

  // Gray-code decoder phases: three clockwise steps, three counter-clockwise steps.
  typedef enum logic [2:0] {
    PH_REST = 3'd0,
    PH_CW1  = 3'd1,
    PH_CW2  = 3'd2,
    PH_CW3  = 3'd3,
    PH_CCW1 = 3'd4,
    PH_CCW2 = 3'd5,
    PH_CCW3 = 3'd6
  } phase_t;

  // Next phase by [phase][ab], ab = {A, B}; the unused code behaves as rest.
  localparam phase_t PHASE_NEXT [8][4] = '{
    '{PH_REST, PH_CW1,  PH_CCW1, PH_REST},
    '{PH_CW2,  PH_CW1,  PH_CW1,  PH_REST},
    '{PH_CW2,  PH_CW1,  PH_CW3,  PH_CW2},
    '{PH_CW2,  PH_CW3,  PH_CW3,  PH_REST},
    '{PH_CCW2, PH_CCW1, PH_CCW1, PH_REST},
    '{PH_CCW2, PH_CCW3, PH_CCW1, PH_CCW2},
    '{PH_CCW2, PH_CCW3, PH_CCW3, PH_REST},
    '{PH_REST, PH_CW1,  PH_CCW1, PH_REST}
  };

  localparam logic [1:0]  AB_BOTH_HIGH = 2'b11;
  localparam logic [31:0] COUNT_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] COUNT_MIN    = 32'h8000_0000;

  localparam logic [15:0] DEBOUNCE_RST     = 16'd30;
  localparam logic [15:0] REST_TIMEOUT_RST = 16'd1000;
  localparam logic [2:0]  CLK_POS_RST      = 3'd4;
  localparam logic [2:0]  DT_POS_RST       = 3'd5;
  localparam logic [2:0]  SWITCH_POS_RST   = 3'd6;

  // Post-update view of one debounce lane.
  typedef struct packed {
    logic pressed;
    logic latch;
  } lane_stat_t;

endpackage

@@ hdl/ebic_enc.sv @@
// Quadrature phase decoder with rest timeout and saturating detent count.
module ebic_enc (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample,
  input  logic        take,
  input  logic [1:0]  ab,
  input  logic [31:0] now_ms,
  input  logic [15:0] rest_timeout_ms,
  output logic [31:0] delta,
  output logic        count_nz
);
  import ebic_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  phase_t      table_phase;
  logic [31:0] change_time;
  logic [31:0] change_time_next;
  logic [31:0] count;
  logic [31:0] count_next;
  logic [31:0] idle_time;

  assign table_phase = PHASE_NEXT[phase][ab];
  assign idle_time   = now_ms - change_time;

  // Next phase and change time.
  always_comb begin
    phase_next       = phase;
    change_time_next = change_time;
    if (sample) begin
      if (table_phase != phase) begin
        phase_next       = table_phase;
        change_time_next = now_ms;
      end else if (phase != PH_REST && idle_time > {16'd0, rest_timeout_ms}) begin
        phase_next = PH_REST;
      end
    end
  end

  // Detent count: step on a completed detent, clear on take.
  always_comb begin
    count_next = count;
    delta      = '0;
    if (sample && ab == AB_BOTH_HIGH) begin
      case (phase)
        PH_CW3: begin
          if (count != COUNT_MAX) count_next = count + 32'd1;
        end
        PH_CCW3: begin
          if (count != COUNT_MIN) count_next = count - 32'd1;
        end
        default: count_next = count;
      endcase
    end else if (take) begin
      delta      = count;
      count_next = '0;
    end
  end

  assign count_nz = (count_next != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_REST;
      change_time <= '0;
      count       <= '0;
    end else begin
      phase       <= phase_next;
      change_time <= change_time_next;
      count       <= count_next;
    end
  end

endmodule

@@ hdl/ebic_lane.sv @@
// One debounce lane: raw change tracking, stable-time accept, press latch.
module ebic_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample,
  input  logic                 consume,
  input  logic                 active,
  input  logic [31:0]          now_ms,
  input  logic [15:0]          debounce_ms,
  output logic                 event_flag,
  output ebic_pkg::lane_stat_t stat
);
  import ebic_pkg::*;

  logic        raw_last;
  logic        raw_last_next;
  logic [31:0] change_time;
  logic [31:0] change_time_next;
  logic        pressed;
  logic        pressed_next;
  logic        latch;
  logic        latch_next;
  logic [31:0] stable_time;

  assign stable_time = now_ms - change_time;

  always_comb begin
    raw_last_next    = raw_last;
    change_time_next = change_time;
    pressed_next     = pressed;
    latch_next       = latch;
    event_flag       = 1'b0;
    if (sample) begin
      if (active != raw_last) begin
        // restart the stable window
        raw_last_next    = active;
        change_time_next = now_ms;
      end else if (stable_time > {16'd0, debounce_ms} && active != pressed) begin
        pressed_next = active;
        if (active) latch_next = 1'b1;
      end
    end else if (consume) begin
      event_flag = latch;
      latch_next = 1'b0;
    end
  end

  assign stat.pressed = pressed_next;
  assign stat.latch   = latch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last    <= 1'b0;
      change_time <= '0;
      pressed     <= 1'b0;
      latch       <= 1'b0;
    end else begin
      raw_last    <= raw_last_next;
      change_time <= change_time_next;
      pressed     <= pressed_next;
      latch       <= latch_next;
    end
  end

endmodule

@@ hdl/ebic_merge.sv @@
// Merge of lane status into the held mask and the pending summary.
module ebic_merge #(
  parameter int NUM_BUTTONS = 4
) (
  input  ebic_pkg::lane_stat_t [NUM_BUTTONS:0] stat,
  input  logic                                 count_nz,
  output logic [3:0]                           held_mask,
  output logic                                 pending_any
);
  import ebic_pkg::*;

  localparam int SW_LANE = NUM_BUTTONS;

  always_comb begin
    held_mask   = '0;
    pending_any = count_nz | stat[SW_LANE].latch;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      pending_any = pending_any | stat[k].latch | stat[k].pressed;
    end
    for (int k = 0; k < 4; k++) begin
      if (k < NUM_BUTTONS) held_mask[k] = stat[k].pressed;
    end
  end

endmodule

@@ hdl/encoder_and_button_input_conditioner.sv @@
// Top level of the encoder and button input conditioner.
// Each accepted item is either a port sample or a request. A sample steps the
// gray-code quadrature decoder (lines A and B on configurable port bits) and,
// in parallel lanes, debounces NUM_BUTTONS active-low buttons on port bits 0
// upward plus the active-low encoder switch. Requests take and clear the
// detent count, consume a button press latch, or consume the switch latch.
// All state updates happen at the accept edge and the result lands in a single
// output register, so a new item is accepted every cycle as long as the output
// register is empty or being drained. The result is valid in the cycle after
// accept. Configuration registers sit on an APB-style port (byte address
// 4*index); the user must see that they are written only while the block is
// idle, as the block itself does not enforce this.
module encoder_and_button_input_conditioner #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  port_bits,
  input  logic [31:0] now_ms,
  input  logic [2:0]  button_index,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] encoder_delta,
  output logic        event_flag,
  output logic [3:0]  held_mask,
  output logic        pending_any
);
  import ebic_pkg::*;

  localparam int NUM_LANES = NUM_BUTTONS + 1;
  localparam int SW_LANE   = NUM_BUTTONS;

  // Configuration registers
  logic [15:0] debounce_ms;
  logic [15:0] rest_timeout_ms;
  logic [2:0]  clk_bit_pos;
  logic [2:0]  dt_bit_pos;
  logic [2:0]  switch_bit_pos;
  reg_idx_t    cfg_idx;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RST;
      rest_timeout_ms <= REST_TIMEOUT_RST;
      clk_bit_pos     <= CLK_POS_RST;
      dt_bit_pos      <= DT_POS_RST;
      switch_bit_pos  <= SWITCH_POS_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_DEBOUNCE:     debounce_ms     <= pwdata[15:0];
        REG_REST_TIMEOUT: rest_timeout_ms <= pwdata[15:0];
        REG_CLK_POS:      clk_bit_pos     <= pwdata[2:0];
        REG_DT_POS:       dt_bit_pos      <= pwdata[2:0];
        REG_SWITCH_POS:   switch_bit_pos  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE:     prdata = {16'd0, debounce_ms};
      REG_REST_TIMEOUT: prdata = {16'd0, rest_timeout_ms};
      REG_CLK_POS:      prdata = {29'd0, clk_bit_pos};
      REG_DT_POS:       prdata = {29'd0, dt_bit_pos};
      REG_SWITCH_POS:   prdata = {29'd0, switch_bit_pos};
      default:          prdata = '0;
    endcase
  end

  // Handshake: advance whenever the output register is free or draining.
  logic  in_fire;
  func_t func_c;
  logic  do_sample;
  logic  do_take;
  logic  do_button;
  logic  do_switch;

  assign in_ready  = ~out_valid | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign func_c    = func_t'(func);
  assign do_sample = in_fire && func_c == FUNC_SAMPLE;
  assign do_take   = in_fire && func_c == FUNC_TAKE_DELTA;
  assign do_button = in_fire && func_c == FUNC_TAKE_BUTTON;
  assign do_switch = in_fire && func_c == FUNC_TAKE_SWITCH;

  // Encoder decoder
  logic [1:0]  ab;
  logic [31:0] delta_c;
  logic        count_nz;

  assign ab = {port_bits[clk_bit_pos], port_bits[dt_bit_pos]};

  ebic_enc u_enc (
    .clk             (clk),
    .rst             (rst),
    .sample          (do_sample),
    .take            (do_take),
    .ab              (ab),
    .now_ms          (now_ms),
    .rest_timeout_ms (rest_timeout_ms),
    .delta           (delta_c),
    .count_nz        (count_nz)
  );

  // Debounce lanes: buttons first, switch in the last lane.
  lane_stat_t [NUM_BUTTONS:0] stat;
  logic [NUM_LANES-1:0]       lane_event;
  logic [NUM_LANES-1:0]       lane_active;
  logic [NUM_LANES-1:0]       lane_consume;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    if (k == SW_LANE) begin : g_sw
      assign lane_active[k]  = ~port_bits[switch_bit_pos];
      assign lane_consume[k] = do_switch;
    end else begin : g_btn
      assign lane_active[k]  = ~port_bits[k];
      assign lane_consume[k] = do_button && ({1'b0, button_index} == 4'(k));
    end

    ebic_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .sample      (do_sample),
      .consume     (lane_consume[k]),
      .active      (lane_active[k]),
      .now_ms      (now_ms),
      .debounce_ms (debounce_ms),
      .event_flag  (lane_event[k]),
      .stat        (stat[k])
    );
  end

  // Merge lane results
  logic [3:0] held_c;
  logic       pending_c;

  ebic_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .stat        (stat),
    .count_nz    (count_nz),
    .held_mask   (held_c),
    .pending_any (pending_c)
  );

  // Output register: hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      encoder_delta <= delta_c;
      event_flag    <= |lane_event;
      held_mask     <= held_c;
      pending_any   <= pending_c;
    end
  end

endmodule
